[rtl/core/pngcp_pkg.sv]
// Shared types and constants for the PNG chunk stream parser.
package pngcp_pkg;

	// Chunk type codes, first byte in the most significant position
	localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
	localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

	// Field sizes in bytes
	localparam logic [31:0] SIG_BYTES  = 32'd8;
	localparam logic [31:0] WORD_BYTES = 32'd4;
	localparam logic [31:0] HDR_BYTES  = 32'd13;
	localparam logic [31:0] WIDTH_END  = 32'd4;
	localparam logic [31:0] HEIGHT_END = 32'd8;

	// One finished-chunk report
	typedef struct packed {
		logic [31:0] chunk_type;
		logic [30:0] chunk_length;
		logic [31:0] chunk_crc;
		logic [30:0] image_width;
		logic [30:0] image_height;
		logic [7:0]  bit_depth;
		logic [7:0]  color_type;
		logic [7:0]  compression_method;
		logic [7:0]  filter_method;
		logic [7:0]  interlace_method;
		logic [31:0] other_chunk_count;
		logic        end_of_image;
	} result_t;

endpackage

[rtl/core/pngcp_skid.sv]
// Output register with a skid stage for chunk reports.
module pngcp_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  pngcp_pkg::result_t in_data,
	output logic              in_ready,
	output logic              out_valid,
	output pngcp_pkg::result_t out_data,
	input  logic              out_ready
);
	import pngcp_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    pop;

	assign pop       = out_valid_q && out_ready;
	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Track occupancy of the output and skid slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Move payload: refill from skid first, else take the new request
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (in_valid) begin
			if (out_valid_q && !pop) begin
				skid_data_q <= in_data;
			end else begin
				out_data_q <= in_data;
			end
		end
	end

endmodule

[rtl/core/png_chunk_stream_parser.sv]
// Top level of the PNG chunk stream parser: byte parser and report output.
//
// Feed a PNG file one byte per request on the s_ side, with s_tuser set on the
// first byte of each file. The eight signature bytes are skipped unchecked,
// then each chunk's length, type, data and CRC are walked; IHDR fields are
// captured, other data is skipped by length, and a report goes out on the m_
// side after the last CRC byte of every chunk (or after the last type byte of
// IEND, marked by m_tlast). After IEND, bytes are dropped until the next
// s_tuser. One byte is taken every cycle that s_tready is high; it falls only
// when both the output register and its skid stage hold reports that the
// downstream side has not taken, and rises again the cycle after one leaves.
module png_chunk_stream_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tuser,   // [0] frame_start
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] chunk_type, [62:32] chunk_length, [94:63] chunk_crc,
	// [125:95] image_width, [156:126] image_height, [164:157] bit_depth,
	// [172:165] color_type, [180:173] compression_method,
	// [188:181] filter_method, [196:189] interlace_method,
	// [228:197] other_chunk_count, [231:229] zero
	output logic [231:0] m_tdata,
	output logic         m_tlast    // end_of_image
);
	import pngcp_pkg::*;

	typedef enum logic [2:0] {
		PH_SIG, PH_LEN, PH_TYPE, PH_HDR, PH_SKIP, PH_CRC, PH_DONE
	} phase_t;

	phase_t      phase_q, phase_c, phase_d;
	logic [31:0] cnt_q, cnt_c, cnt_d, cnt_inc;
	logic [31:0] len_q, len_c, len_d;
	logic [31:0] typ_q, typ_c, typ_d;
	logic [31:0] crc_q, crc_c, crc_d;
	logic [30:0] wid_q, wid_c, wid_d;
	logic [30:0] hgt_q, hgt_c, hgt_d;
	logic [39:0] hdr_q, hdr_c, hdr_d;
	logic [31:0] other_q, other_c, other_d;
	logic        emit_d, eoi_d;
	logic        accept, push;
	result_t     res_d, res_out;
	logic [7:0]  b;

	assign b      = s_tdata;
	assign accept = s_tvalid && s_tready;
	assign push   = accept && emit_d;

	// Step the parser on one byte
	always_comb begin
		// frame start restarts from the reset state
		phase_c = s_tuser ? PH_SIG : phase_q;
		cnt_c   = s_tuser ? '0 : cnt_q;
		len_c   = s_tuser ? '0 : len_q;
		typ_c   = s_tuser ? '0 : typ_q;
		crc_c   = s_tuser ? '0 : crc_q;
		wid_c   = s_tuser ? '0 : wid_q;
		hgt_c   = s_tuser ? '0 : hgt_q;
		hdr_c   = s_tuser ? '0 : hdr_q;
		other_c = s_tuser ? '0 : other_q;

		cnt_inc = cnt_c + 32'd1;
		phase_d = phase_c;
		cnt_d   = cnt_c;
		len_d   = len_c;
		typ_d   = typ_c;
		crc_d   = crc_c;
		wid_d   = wid_c;
		hgt_d   = hgt_c;
		hdr_d   = hdr_c;
		other_d = other_c;
		emit_d  = 1'b0;
		eoi_d   = 1'b0;

		unique case (phase_c)
			PH_SIG: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= SIG_BYTES) begin
					phase_d = PH_LEN;
					cnt_d   = '0;
				end
			end
			PH_LEN: begin
				len_d = {len_c[23:0], b};
				cnt_d = cnt_inc;
				if (cnt_inc >= WORD_BYTES) begin
					phase_d = PH_TYPE;
					cnt_d   = '0;
				end
			end
			PH_TYPE: begin
				typ_d = {typ_c[23:0], b};
				cnt_d = cnt_inc;
				if (cnt_inc >= WORD_BYTES) begin
					cnt_d = '0;
					if (typ_d == TYPE_IEND) begin
						phase_d = PH_DONE;
						emit_d  = 1'b1;
						eoi_d   = 1'b1;
					end else if (typ_d == TYPE_IHDR) begin
						phase_d = PH_HDR;
					end else begin
						other_d = other_c + 32'd1;
						phase_d = (len_c == '0) ? PH_CRC : PH_SKIP;
					end
				end
			end
			PH_HDR: begin
				if (cnt_c < WIDTH_END) begin
					wid_d = {wid_c[22:0], b};
				end else if (cnt_c < HEIGHT_END) begin
					hgt_d = {hgt_c[22:0], b};
				end else if (cnt_c < HDR_BYTES) begin
					hdr_d = {hdr_c[31:0], b};
				end
				cnt_d = cnt_inc;
				if (cnt_inc >= HDR_BYTES && cnt_inc >= len_c) begin
					phase_d = PH_CRC;
					cnt_d   = '0;
				end
			end
			PH_SKIP: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= len_c) begin
					phase_d = PH_CRC;
					cnt_d   = '0;
				end
			end
			PH_CRC: begin
				crc_d = {crc_c[23:0], b};
				cnt_d = cnt_inc;
				if (cnt_inc >= WORD_BYTES) begin
					cnt_d   = '0;
					phase_d = PH_LEN;
					emit_d  = 1'b1;
				end
			end
			default: begin
				// finished: drop the byte
			end
		endcase

		res_d.chunk_type         = typ_d;
		res_d.chunk_length       = len_d[30:0];
		res_d.chunk_crc          = eoi_d ? '0 : crc_d;
		res_d.image_width        = wid_d;
		res_d.image_height       = hgt_d;
		res_d.bit_depth          = hdr_d[39:32];
		res_d.color_type         = hdr_d[31:24];
		res_d.compression_method = hdr_d[23:16];
		res_d.filter_method      = hdr_d[15:8];
		res_d.interlace_method   = hdr_d[7:0];
		res_d.other_chunk_count  = other_d;
		res_d.end_of_image       = eoi_d;
	end

	// Hold parser state; advance on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG;
			cnt_q   <= '0;
			len_q   <= '0;
			typ_q   <= '0;
			crc_q   <= '0;
			wid_q   <= '0;
			hgt_q   <= '0;
			hdr_q   <= '0;
			other_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			len_q   <= len_d;
			typ_q   <= typ_d;
			crc_q   <= crc_d;
			wid_q   <= wid_d;
			hgt_q   <= hgt_d;
			hdr_q   <= hdr_d;
			other_q <= other_d;
		end
	end

	pngcp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push),
		.in_data   (res_d),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_data  (res_out),
		.out_ready (m_tready)
	);

	// Pack the report onto the master side
	assign m_tdata = {3'b000, res_out.other_chunk_count, res_out.interlace_method,
		res_out.filter_method, res_out.compression_method, res_out.color_type,
		res_out.bit_depth, res_out.image_height, res_out.image_width,
		res_out.chunk_crc, res_out.chunk_length, res_out.chunk_type};
	assign m_tlast = res_out.end_of_image;

`ifndef ASSERT_OFF
	a_eoi_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		push && eoi_d |=> phase_q == PH_DONE)
		else $error("IEND report did not leave the parser finished");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !s_tuser && phase_q == PH_DONE |-> !push)
		else $error("report raised after IEND without frame start");

	a_sig_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SIG |-> cnt_q < SIG_BYTES)
		else $error("signature byte count out of range");

	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LEN || phase_q == PH_TYPE || phase_q == PH_CRC
		|-> cnt_q < WORD_BYTES)
		else $error("word byte count out of range");
`endif

endmodule

[tb/png_report_checker.sv]
// Predicts PNG chunk reports from accepted stream bytes and compares them with the parser's output.
module png_report_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [231:0] m_tdata,
	input  logic         m_tlast,
	output int           mismatches,
	output int           pending
);
	import pngcp_pkg::*;

	typedef enum logic [2:0] {
		PH_SIGNATURE,
		PH_LENGTH,
		PH_TYPE,
		PH_HEADER,
		PH_SKIP,
		PH_CRC,
		PH_DONE
	} parse_phase_t;

	// Predicted parser state
	parse_phase_t phase;
	logic [31:0]  byte_cnt;
	logic [31:0]  len_word;
	logic [31:0]  type_word;
	logic [31:0]  crc_word;
	logic [31:0]  width_word;
	logic [31:0]  height_word;
	logic [39:0]  tail_bytes;
	logic [31:0]  other_count;
	logic         stopped;

	result_t expected_reports[$];

	task automatic clear_state();
		phase       = PH_SIGNATURE;
		byte_cnt    = '0;
		len_word    = '0;
		type_word   = '0;
		crc_word    = '0;
		width_word  = '0;
		height_word = '0;
		tail_bytes  = '0;
		other_count = '0;
		stopped     = 1'b0;
	endtask

	function automatic result_t make_report(input logic [31:0] crc, input logic eoi);
		result_t r;
		r.chunk_type         = type_word;
		r.chunk_length       = len_word[30:0];
		r.chunk_crc          = crc;
		r.image_width        = width_word[30:0];
		r.image_height       = height_word[30:0];
		r.bit_depth          = tail_bytes[39:32];
		r.color_type         = tail_bytes[31:24];
		r.compression_method = tail_bytes[23:16];
		r.filter_method      = tail_bytes[15:8];
		r.interlace_method   = tail_bytes[7:0];
		r.other_chunk_count  = other_count;
		r.end_of_image       = eoi;
		return r;
	endfunction

	// Advance the predicted parser by one byte, queue a report when a chunk finishes
	task automatic parse_byte(input logic [7:0] b, input logic start);
		logic [31:0] c;
		if (start)
			clear_state();
		if (!stopped) begin
			c = byte_cnt;
			case (phase)
				PH_SIGNATURE: begin
					c = c + 1;
					if (c >= SIG_BYTES) begin
						phase = PH_LENGTH;
						c = '0;
					end
				end
				PH_LENGTH: begin
					len_word = {len_word[23:0], b};
					c = c + 1;
					if (c >= WORD_BYTES) begin
						phase = PH_TYPE;
						c = '0;
					end
				end
				PH_TYPE: begin
					type_word = {type_word[23:0], b};
					c = c + 1;
					if (c >= WORD_BYTES) begin
						c = '0;
						if (type_word == TYPE_IEND) begin
							phase   = PH_DONE;
							stopped = 1'b1;
							expected_reports.push_back(make_report(32'd0, 1'b1));
						end else if (type_word == TYPE_IHDR) begin
							phase = PH_HEADER;
						end else begin
							other_count = other_count + 1;
							if (len_word == 32'd0)
								phase = PH_CRC;
							else
								phase = PH_SKIP;
						end
					end
				end
				PH_HEADER: begin
					if (c < WIDTH_END)
						width_word = {width_word[23:0], b};
					else if (c < HEIGHT_END)
						height_word = {height_word[23:0], b};
					else if (c < HDR_BYTES)
						tail_bytes = {tail_bytes[31:0], b};
					c = c + 1;
					// short headers still take all 13 bytes, long ones run to the length
					if (c >= HDR_BYTES && c >= len_word) begin
						phase = PH_CRC;
						c = '0;
					end
				end
				PH_SKIP: begin
					c = c + 1;
					if (c >= len_word) begin
						phase = PH_CRC;
						c = '0;
					end
				end
				PH_CRC: begin
					crc_word = {crc_word[23:0], b};
					c = c + 1;
					if (c >= WORD_BYTES) begin
						c = '0;
						phase = PH_LENGTH;
						expected_reports.push_back(make_report(crc_word, 1'b0));
					end
				end
				default: ;
			endcase
			byte_cnt = c;
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
			mismatches++;
		end
	endtask

	// Compare one delivered report with the oldest prediction
	task automatic check_report();
		result_t want;
		if (expected_reports.size() == 0) begin
			if (mismatches < 10)
				$display("%0t: report with none expected: type %h crc %h", $realtime,
					m_tdata[31:0], m_tdata[94:63]);
			mismatches++;
		end else begin
			want = expected_reports.pop_front();
			compare_field("chunk_type", want.chunk_type, m_tdata[31:0]);
			compare_field("chunk_length", 32'(want.chunk_length), 32'(m_tdata[62:32]));
			compare_field("chunk_crc", want.chunk_crc, m_tdata[94:63]);
			compare_field("image_width", 32'(want.image_width), 32'(m_tdata[125:95]));
			compare_field("image_height", 32'(want.image_height),
				32'(m_tdata[156:126]));
			compare_field("bit_depth", 32'(want.bit_depth), 32'(m_tdata[164:157]));
			compare_field("color_type", 32'(want.color_type), 32'(m_tdata[172:165]));
			compare_field("compression_method", 32'(want.compression_method),
				32'(m_tdata[180:173]));
			compare_field("filter_method", 32'(want.filter_method),
				32'(m_tdata[188:181]));
			compare_field("interlace_method", 32'(want.interlace_method),
				32'(m_tdata[196:189]));
			compare_field("other_chunk_count", want.other_chunk_count, m_tdata[228:197]);
			compare_field("end_of_image", 32'(want.end_of_image), 32'(m_tlast));
		end
	endtask

	// Watch both channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			expected_reports.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready)
				check_report();
			pending = expected_reports.size();
		end
	end

endmodule

[tb/tb_top.sv]
// Top of the PNG chunk parser testbench: clock, reset, byte stream stimulus and verdict.
module tb_top;
	import pngcp_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       start;
	} stream_byte_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'd0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [231:0] m_tdata;
	logic         m_tlast;
	int           mismatches;
	int           pending;

	stream_byte_t file_bytes[$];
	int           quiet_from;
	bit           long_hold_due = 1'b0;
	bit           calm = 1'b0;

	png_chunk_stream_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	png_report_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	task automatic add_byte(input logic [7:0] d, input logic st);
		stream_byte_t item;
		item.data  = d;
		item.start = st;
		file_bytes.push_back(item);
	endtask

	task automatic add_word(input logic [31:0] w);
		add_byte(w[31:24], 1'b0);
		add_byte(w[23:16], 1'b0);
		add_byte(w[15:8], 1'b0);
		add_byte(w[7:0], 1'b0);
	endtask

	function automatic logic [31:0] other_type();
		logic [31:0] t;
		t = $urandom;
		if (t == TYPE_IHDR || t == TYPE_IEND)
			t = t ^ 32'h1;
		return t;
	endfunction

	// Mark the first byte as frame start; signature content is never checked
	task automatic add_signature();
		add_byte(8'($urandom_range(0, 255)), 1'b1);
		repeat (7)
			add_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic add_header(input int len);
		int n;
		n = (len < 13) ? 13 : len;
		add_word(len);
		add_word(TYPE_IHDR);
		repeat (n)
			add_byte(8'($urandom_range(0, 255)), 1'b0);
		add_word($urandom);
	endtask

	task automatic add_other(input int len);
		add_word(len);
		add_word(other_type());
		repeat (len)
			add_byte(8'($urandom_range(0, 255)), 1'b0);
		add_word($urandom);
	endtask

	// One random file: mostly well formed, some cut short or trailing into noise
	task automatic add_file();
		int n_chunks;
		int ending;
		int sel;
		add_signature();
		if ($urandom_range(0, 9) != 0) begin
			sel = $urandom_range(0, 5);
			if (sel == 0)
				add_header($urandom_range(0, 12));
			else if (sel == 1)
				add_header($urandom_range(14, 20));
			else
				add_header(13);
		end
		n_chunks = $urandom_range(0, 4);
		repeat (n_chunks) begin
			if ($urandom_range(0, 7) == 0)
				add_header(13);
			else if ($urandom_range(0, 3) == 0)
				add_other(0);
			else
				add_other($urandom_range(1, 16));
		end
		ending = $urandom_range(0, 9);
		if (ending < 8) begin
			add_word($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0);
			add_word(TYPE_IEND);
			repeat ($urandom_range(0, 3))
				add_byte(8'($urandom_range(0, 255)), 1'b0);
		end else if (ending == 8) begin
			add_word($urandom_range(1, 40));
			add_word(other_type());
			repeat ($urandom_range(0, 5))
				add_byte(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			repeat ($urandom_range(1, 10))
				add_byte(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	task automatic build_stream();
		// Short header: all-ones width, zero height, mixed tail bytes
		add_signature();
		add_word(32'd0);
		add_word(TYPE_IHDR);
		add_word(32'hFFFF_FFFF);
		add_word(32'h0000_0000);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hA5, 1'b0);
		add_byte(8'h5A, 1'b0);
		add_byte(8'h01, 1'b0);
		add_word(32'hFFFF_FFFF);
		// Empty chunk, then a long header
		add_other(0);
		add_header(15);
		// End with nonzero length; trailing bytes are dropped
		add_word(32'd7);
		add_word(TYPE_IEND);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		// Huge length cut off by the next frame start
		add_signature();
		add_word(32'hFFFF_FFFF);
		add_word(other_type());
		repeat (3)
			add_byte(8'($urandom_range(0, 255)), 1'b0);
		while (file_bytes.size() < 680)
			add_file();
		add_file();
	endtask

	// Limit
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Receiver: random stalls, one long hold-off, none near the end
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold_due) begin
				long_hold_due = 1'b0;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(0, calm ? 0 : 30)) @(posedge clk);
		end
	end

	// Sender and verdict
	initial begin
		int idx;
		build_stream();
		quiet_from = file_bytes.size() - 120;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (idx = 0; idx < file_bytes.size(); idx++) begin
			if (idx == 300)
				long_hold_due = 1'b1;
			if (idx >= quiet_from)
				calm = 1'b1;
			// idle with junk on the bus
			if (!calm && $urandom_range(0, 4) == 0) begin
				s_tvalid <= 1'b0;
				s_tdata  <= 8'($urandom_range(0, 255));
				s_tuser  <= 1'($urandom_range(0, 1));
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= file_bytes[idx].data;
			s_tuser  <= file_bytes[idx].start;
			// hold the request until it is taken
			@(negedge clk);
			while (!s_tready)
				@(negedge clk);
			@(posedge clk);
		end
		s_tvalid <= 1'b0;
		s_tuser  <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[png_chunk_stream_parser.f]
rtl/core/pngcp_pkg.sv
rtl/core/pngcp_skid.sv
rtl/core/png_chunk_stream_parser.sv
tb/png_report_checker.sv
tb/tb_top.sv
